// ----- sv/adc_decimator_clip_detect_unit_assert.svh -----
// assertion macros shared by the decimator rtl
// depends on nothing; included by modules that carry concurrent checks
`ifndef ADC_DECIMATOR_CLIP_DETECT_UNIT_ASSERT_SVH
`define ADC_DECIMATOR_CLIP_DETECT_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ADCDC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ADCDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/adcdc_pkg.sv -----
// shared types, constants and coefficient table of the adc decimator
// depends on nothing
package adcdc_pkg;

   localparam int ADC_W        = 12;
   localparam int SAMPLE_W     = 16;
   localparam int OUT_W        = 16;
   localparam int CLIP_LEVEL_W = 15;
   localparam int RUN_W        = 4;
   localparam int CSR_DATA_W   = 15;
   localparam int CSR_INDEX_W  = 1;
   localparam int FRAC_BITS    = 15;
   localparam int TABLE_LEN    = 31;

   localparam logic [CLIP_LEVEL_W-1:0] CLIP_LEVEL_RESET = 15'd32113;
   localparam logic [RUN_W-1:0]        CLIP_RUN_RESET   = 4'd7;
   localparam logic [RUN_W-1:0]        CLIP_COUNT_MAX   = 4'd15;

   // register indexes of the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLIP_LEVEL = 1'b0,
      CSR_CLIP_RUN   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ADC_W-1:0] adc_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] filtered_sample;
      logic                    clip_flag;
   } rsp_payload_type;

   // control of the tap cell row
   typedef struct packed {
      logic shift;   // new sample enters the delay line
      logic load;    // delay line copied into the scan chain
      logic step;    // scan chain moves one cell toward the tail
   } cell_ctrl_type;

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic clear;   // start a new sum
      logic mult_en; // multiply the tail sample this cycle
   } mac_ctrl_type;

   // symmetric lowpass table, q15
   localparam logic signed [31:0] LOWPASS_TABLE [TABLE_LEN] = '{
      -32'sd56, 32'sd0, 32'sd96, 32'sd0, -32'sd221, 32'sd0, 32'sd462, 32'sd0,
      -32'sd878, 32'sd0, 32'sd1609, 32'sd0, -32'sd3176, 32'sd0, 32'sd10342,
      32'sd16410, 32'sd10342, 32'sd0, -32'sd3176, 32'sd0, 32'sd1609, 32'sd0,
      -32'sd878, 32'sd0, 32'sd462, 32'sd0, -32'sd221, 32'sd0, 32'sd96, 32'sd0,
      -32'sd56
   };

   // taps past the end of the table get zero
   function automatic logic signed [31:0] lowpass_coef(input int idx);
      logic signed [31:0] coef;
      coef = '0;
      if (idx >= 0 && idx < TABLE_LEN) begin
         coef = LOWPASS_TABLE[idx];
      end
      return coef;
   endfunction

endpackage

// ----- sv/adcdc_chan_if.sv -----
// valid/ready channel carrying one payload item per transfer
// depends on the payload types of adcdc_pkg, chosen at instantiation
interface adcdc_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ----- sv/adcdc_tap_cell.sv -----
// one delay line cell: holds a stored sample and a scan copy of it
// depends on adcdc_pkg
module adcdc_tap_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  adcdc_pkg::cell_ctrl_type              ctrl,
   input  logic signed [adcdc_pkg::SAMPLE_W-1:0] sample_prev,
   input  logic signed [adcdc_pkg::SAMPLE_W-1:0] scan_prev,
   output logic signed [adcdc_pkg::SAMPLE_W-1:0] sample,
   output logic signed [adcdc_pkg::SAMPLE_W-1:0] scan
);

   logic signed [adcdc_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [adcdc_pkg::SAMPLE_W-1:0] scan_ff, scan_in;

   // delay line takes the neighbor's sample on every input transfer
   assign sample_in = ctrl.shift ? sample_prev : sample_ff;

   // scan copy is loaded from the updated sample, then walks to the tail
   always_comb begin
      scan_in = scan_ff;
      if (ctrl.load) begin
         scan_in = sample_in;
      end else if (ctrl.step) begin
         scan_in = scan_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
   end

   assign sample = sample_ff;
   assign scan   = scan_ff;

endmodule

// ----- sv/adcdc_mac.sv -----
// shared multiply-accumulate unit walking the tap chain one tap a cycle
// depends on adcdc_pkg for the coefficient table and control struct
module adcdc_mac #(
   parameter int COEF_WIDTH = 16,
   parameter int CNT_W      = 5,
   parameter int ACC_W      = 38
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  adcdc_pkg::mac_ctrl_type               ctrl,
   input  logic [CNT_W-1:0]                      coef_index,
   input  logic signed [adcdc_pkg::SAMPLE_W-1:0] tap_sample,
   output logic signed [ACC_W-1:0]               acc
);

   localparam int PROD_W = adcdc_pkg::SAMPLE_W + COEF_WIDTH;

   logic signed [31:0]         coef_full;
   logic signed [COEF_WIDTH-1:0] coef;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       prod_vld_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;

   // coefficient for this tap, low bits sign-extended by the signed product
   assign coef_full = adcdc_pkg::lowpass_coef(int'(coef_index));
   assign coef      = coef_full[COEF_WIDTH-1:0];
   assign prod_in   = tap_sample * coef;

   // product register
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.mult_en;
      end
   end

   // accumulate registered products
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- sv/adc_decimator_clip_detect_unit.sv -----
// Sequence: the input that completes a decimation group starts the tap walk in S_MAC,
// followed by S_FINAL, S_OUT and the output register; other inputs are taken in S_IDLE.
// Throughput: one result per 2**DECIM_LOG2 inputs; no input is taken while a result is
// computed or waits on a stalled output, as the single shared multiplier steps the taps.
// Reset: synchronous active high; clears delay line, phase and run count, csrs to defaults.
module adc_decimator_clip_detect_unit #(
   parameter int TAP_COUNT  = 31,
   parameter int DECIM_LOG2 = 1,
   parameter int COEF_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   adcdc_chan_if.sink                             req_if,
   adcdc_chan_if.source                           rsp_if,
   input  logic                                   csr_we,
   input  logic [adcdc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [adcdc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

`include "adc_decimator_clip_detect_unit_assert.svh"

   localparam int CNT_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
   localparam int SUM_W  = adcdc_pkg::SAMPLE_W + COEF_WIDTH + $clog2(TAP_COUNT + 1);
   localparam int ACC_W  = (SUM_W > 32) ? SUM_W : 32;
   localparam int SW     = adcdc_pkg::SAMPLE_W;
   localparam int OW     = adcdc_pkg::OUT_W;
   localparam int FB     = adcdc_pkg::FRAC_BITS;
   localparam logic [CNT_W-1:0] LAST_TAP = CNT_W'(TAP_COUNT - 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MAC   = 4'b0010,
      S_FINAL = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [DECIM_LOG2-1:0]              phase_ff, phase_in;
   logic [adcdc_pkg::RUN_W-1:0]        clip_count_ff, clip_count_in;
   logic [adcdc_pkg::CLIP_LEVEL_W-1:0] clip_level_ff, clip_level_in;
   logic [adcdc_pkg::RUN_W-1:0]        clip_run_ff, clip_run_in;
   logic                               rsp_vld_ff, rsp_vld_in;
   adcdc_pkg::rsp_payload_type         rsp_data_ff, rsp_data_in;

   logic                               req_xfer, start, slot_free, emit;
   logic signed [SW-1:0]               new_sample;
   logic signed [SW-1:0]               sample_w [TAP_COUNT];
   logic signed [SW-1:0]               scan_w   [TAP_COUNT];
   adcdc_pkg::cell_ctrl_type           cell_ctrl;
   adcdc_pkg::mac_ctrl_type            mac_ctrl;
   logic signed [ACC_W-1:0]            acc;
   logic signed [ACC_W-FB-1:0]         acc_shr;
   logic signed [OW-1:0]               y;
   logic [OW-1:0]                      mag;
   logic                               clipped;

   // input transfer and decimation phase
   assign req_if.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign start        = req_xfer && (phase_ff == '1);
   assign phase_in     = req_xfer ? phase_ff + 1'b1 : phase_ff;

   // recenter and scale to q15: flipping the msb subtracts mid-scale
   assign new_sample = {~req_if.payload.adc_sample[adcdc_pkg::ADC_W-1],
                        req_if.payload.adc_sample[adcdc_pkg::ADC_W-2:0],
                        {(SW - adcdc_pkg::ADC_W){1'b0}}};

   // row of tap cells
   assign cell_ctrl.shift = req_xfer;
   assign cell_ctrl.load  = start;
   assign cell_ctrl.step  = (state_ff == S_MAC);

   for (genvar i = 0; i < TAP_COUNT; i++) begin : g_cell
      if (i == 0) begin : g_head
         adcdc_tap_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .sample_prev (new_sample),
            .scan_prev   ({SW{1'b0}}),
            .sample      (sample_w[i]),
            .scan        (scan_w[i])
         );
      end else begin : g_body
         adcdc_tap_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .sample_prev (sample_w[i-1]),
            .scan_prev   (scan_w[i-1]),
            .sample      (sample_w[i]),
            .scan        (scan_w[i])
         );
      end
   end

   // shared multiply-accumulate on the tail of the scan chain
   assign mac_ctrl.clear   = start;
   assign mac_ctrl.mult_en = (state_ff == S_MAC);

   adcdc_mac #(
      .COEF_WIDTH (COEF_WIDTH),
      .CNT_W      (CNT_W),
      .ACC_W      (ACC_W)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .coef_index (count_ff),
      .tap_sample (scan_w[TAP_COUNT-1]),
      .acc        (acc)
   );

   // sequencer
   assign slot_free = !rsp_vld_ff || rsp_if.ready;
   assign emit      = (state_ff == S_OUT) && slot_free;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_MAC;
               count_in = '0;
            end
         end
         S_MAC: begin
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_TAP) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // floor shift by 15 and saturate to 16 bits
   assign acc_shr = acc[ACC_W-1:FB];
   always_comb begin
      if (acc_shr[ACC_W-FB-1:OW-1] == '0 || acc_shr[ACC_W-FB-1:OW-1] == '1) begin
         y = acc_shr[OW-1:0];
      end else if (acc_shr[ACC_W-FB-1]) begin
         y = {1'b1, {(OW-1){1'b0}}};
      end else begin
         y = {1'b0, {(OW-1){1'b1}}};
      end
   end

   // clip run counter, saturating
   assign mag     = y[OW-1] ? OW'(-y) : OW'(y);
   assign clipped = (mag >= {1'b0, clip_level_ff});

   always_comb begin
      clip_count_in = clip_count_ff;
      if (emit) begin
         if (!clipped) begin
            clip_count_in = '0;
         end else if (clip_count_ff != adcdc_pkg::CLIP_COUNT_MAX) begin
            clip_count_in = clip_count_ff + 1'b1;
         end
      end
   end

   // output register
   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_if.ready;
      if (emit) begin
         rsp_vld_in                  = 1'b1;
         rsp_data_in.filtered_sample = y;
         rsp_data_in.clip_flag       = (clip_count_in >= clip_run_ff);
      end
   end

   // csr writes
   always_comb begin
      clip_level_in = clip_level_ff;
      clip_run_in   = clip_run_ff;
      if (csr_we) begin
         unique case (csr_index)
            adcdc_pkg::CSR_CLIP_LEVEL: begin
               clip_level_in = csr_wdata[adcdc_pkg::CLIP_LEVEL_W-1:0];
            end
            adcdc_pkg::CSR_CLIP_RUN: begin
               clip_run_in = csr_wdata[adcdc_pkg::RUN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         phase_ff      <= '0;
         clip_count_ff <= '0;
         clip_level_ff <= adcdc_pkg::CLIP_LEVEL_RESET;
         clip_run_ff   <= adcdc_pkg::CLIP_RUN_RESET;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         phase_ff      <= phase_in;
         clip_count_ff <= clip_count_in;
         clip_level_ff <= clip_level_in;
         clip_run_ff   <= clip_run_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid   = rsp_vld_ff;
   assign rsp_if.payload = rsp_data_ff;

   // checks
   `ADCDC_ASSERT_NEXT(a_start_mac, clock, reset, start, (state_ff == S_MAC) && (count_ff == '0), "group-completing input did not start the tap walk")
   `ADCDC_ASSERT_NEXT(a_walk_end, clock, reset, (state_ff == S_MAC) && (count_ff == LAST_TAP), state_ff == S_FINAL, "tap walk did not end after the last tap")
   `ADCDC_ASSERT_NEXT(a_emit_valid, clock, reset, emit, rsp_if.valid, "finished result not presented")

endmodule

// ----- verif/tb.sv -----
// testbench of adc_decimator_clip_detect_unit: a table of directed transfers, then
// random signal bursts under several clip settings, checked against a local filter model
// depends on adcdc_pkg, adcdc_chan_if and the decimator rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAPS          = 31;
   localparam int SETTLE_CYCLES = 48;
   localparam int DIRECTED_ROWS = 26;
   localparam int SEGMENTS      = 9;
   localparam int SEG_ITEMS     = 60;

   // shapes of the random signal bursts
   typedef enum logic [2:0] {
      SIG_FULL_HIGH,
      SIG_FULL_LOW,
      SIG_NEAR_HIGH,
      SIG_NEAR_LOW,
      SIG_NOISE,
      SIG_MID,
      SIG_TOGGLE
   } signal_shape_type;

   // one row of the directed script: a csr write or a sample transfer
   typedef struct packed {
      logic                                 is_csr;
      adcdc_pkg::csr_index_type             csr_sel;
      logic [adcdc_pkg::CSR_DATA_W-1:0]     csr_value;
      logic [adcdc_pkg::ADC_W-1:0]          sample;
      logic                                 known;
      adcdc_pkg::rsp_payload_type           known_rsp;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                              csr_we;
   logic [adcdc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [adcdc_pkg::CSR_DATA_W-1:0]  csr_wdata;

   adcdc_chan_if #(.payload_type(adcdc_pkg::req_payload_type)) req_if ();
   adcdc_chan_if #(.payload_type(adcdc_pkg::rsp_payload_type)) rsp_if ();

   adc_decimator_clip_detect_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // filter model state and its copy of the csrs
   logic signed [adcdc_pkg::SAMPLE_W-1:0] taps [TAPS];
   logic                                  decim_phase;
   logic [adcdc_pkg::RUN_W-1:0]           run_count;
   logic [adcdc_pkg::CLIP_LEVEL_W-1:0]    level_reg;
   logic [adcdc_pkg::RUN_W-1:0]           run_len_reg;

   adcdc_pkg::rsp_payload_type pending_outputs[$];
   int mismatches = 0;
   int sender_gap_pct = 0;
   int receiver_stall_pct = 0;

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // symmetric lowpass table, odd taps away from the center are zero
   function automatic int coef_of(input int idx);
      int k;
      k = (idx <= 15) ? idx : 30 - idx;
      case (k)
         0:       return -56;
         2:       return 96;
         4:       return -221;
         6:       return 462;
         8:       return -878;
         10:      return 1609;
         12:      return -3176;
         14:      return 10342;
         15:      return 16410;
         default: return 0;
      endcase
   endfunction

   function automatic void clear_filter_state();
      foreach (taps[k]) taps[k] = '0;
      decim_phase = 1'b0;
      run_count   = '0;
      level_reg   = adcdc_pkg::CLIP_LEVEL_RESET;
      run_len_reg = adcdc_pkg::CLIP_RUN_RESET;
   endfunction

   // shift one sample in; on every second sample compute the decimated output
   function automatic bit lowpass_step(input logic [adcdc_pkg::ADC_W-1:0] s,
                                       output adcdc_pkg::rsp_payload_type r);
      longint acc;
      int q;
      int mag;
      r = '0;
      for (int k = TAPS - 1; k > 0; k--) taps[k] = taps[k-1];
      taps[0] = 16'((int'(s) - 2048) * 16);
      decim_phase = ~decim_phase;
      if (decim_phase) return 1'b0;
      acc = 0;
      for (int k = 0; k < TAPS; k++) begin
         acc += longint'(coef_of(TAPS - 1 - k)) * longint'(taps[k]);
      end
      // floor shift, then saturate to 16 bits
      q = int'(acc >>> adcdc_pkg::FRAC_BITS);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      mag = (q < 0) ? -q : q;
      // saturating run counter of clipped outputs
      if (mag >= int'(level_reg)) begin
         if (run_count != adcdc_pkg::CLIP_COUNT_MAX) run_count = run_count + 1'b1;
      end else begin
         run_count = '0;
      end
      r.filtered_sample = 16'(q);
      r.clip_flag       = (run_count >= run_len_reg);
      return 1'b1;
   endfunction

   function automatic script_row_type item_row(input logic [adcdc_pkg::ADC_W-1:0] s);
      script_row_type row;
      row = '0;
      row.sample = s;
      return row;
   endfunction

   function automatic script_row_type csr_row(input adcdc_pkg::csr_index_type sel,
                                              input logic [adcdc_pkg::CSR_DATA_W-1:0] value);
      script_row_type row;
      row = '0;
      row.is_csr    = 1'b1;
      row.csr_sel   = sel;
      row.csr_value = value;
      return row;
   endfunction

   // directed script: extremes, bit patterns, a known first output, zero run length
   function automatic script_row_type script_row(input int n);
      script_row_type row;
      case (n)
         0:  row = item_row(12'd2048);
         1:  begin
            // two mid-scale samples after reset give a zero first output
            row = item_row(12'd2048);
            row.known     = 1'b1;
            row.known_rsp = '{filtered_sample: 16'sd0, clip_flag: 1'b0};
         end
         2:  row = item_row(12'd0);
         3:  row = item_row(12'd0);
         4:  row = item_row(12'd4095);
         5:  row = item_row(12'd4095);
         6:  row = item_row(12'hAAA);
         7:  row = item_row(12'h555);
         8:  row = item_row(12'd1);
         9:  row = item_row(12'd4094);
         10: row = item_row(12'd2047);
         11: row = item_row(12'd2049);
         12: row = csr_row(adcdc_pkg::CSR_CLIP_LEVEL, 15'd0);
         13: row = csr_row(adcdc_pkg::CSR_CLIP_RUN, 15'd0);
         14: row = item_row(12'd4095);
         15: row = item_row(12'd4095);
         16: row = item_row(12'd2048);
         17: row = item_row(12'd2048);
         18: row = csr_row(adcdc_pkg::CSR_CLIP_LEVEL, 15'd32767);
         19: row = csr_row(adcdc_pkg::CSR_CLIP_RUN, 15'd15);
         default: row = item_row((n % 2 == 0) ? 12'd4095 : 12'd0);
      endcase
      return row;
   endfunction

   // one sample transfer; valid stays up after it so back-to-back transfers need no gap
   task automatic send_sample(input logic [adcdc_pkg::ADC_W-1:0] s, input logic known,
                              input adcdc_pkg::rsp_payload_type known_rsp);
      adcdc_pkg::rsp_payload_type r;
      while ($urandom_range(99) < sender_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload.adc_sample <= s;
      do @(posedge clock); while (!req_if.ready);
      if (lowpass_step(s, r)) pending_outputs.push_back(known ? known_rsp : r);
   endtask

   // csr write once the block has gone quiet
   task automatic write_csr(input adcdc_pkg::csr_index_type sel,
                            input logic [adcdc_pkg::CSR_DATA_W-1:0] value);
      req_if.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (sel == adcdc_pkg::CSR_CLIP_LEVEL) level_reg = value[adcdc_pkg::CLIP_LEVEL_W-1:0];
      else run_len_reg = value[adcdc_pkg::RUN_W-1:0];
   endtask

   function automatic logic [adcdc_pkg::ADC_W-1:0] shaped_sample(
      input signal_shape_type shape, input int n);
      case (shape)
         SIG_FULL_HIGH: return 12'd4095;
         SIG_FULL_LOW:  return 12'd0;
         SIG_NEAR_HIGH: return 12'($urandom_range(4095, 3900));
         SIG_NEAR_LOW:  return 12'($urandom_range(195, 0));
         SIG_MID:       return 12'($urandom_range(2200, 1900));
         SIG_TOGGLE:    return (n % 2 == 0) ? 12'd4095 : 12'd0;
         default:       return 12'($urandom_range(4095, 0));
      endcase
   endfunction

   function automatic signal_shape_type pick_shape();
      case ($urandom_range(9))
         0, 1:    return SIG_FULL_HIGH;
         2, 3:    return SIG_FULL_LOW;
         4:       return SIG_NEAR_HIGH;
         5:       return SIG_NEAR_LOW;
         8:       return SIG_MID;
         9:       return SIG_TOGGLE;
         default: return SIG_NOISE;
      endcase
   endfunction

   // pacing phases over the run: receiver stalls first, then sender gaps, then none
   function automatic void set_pacing(input int seg);
      case (seg / 3)
         0: begin sender_gap_pct = 23; receiver_stall_pct = 63; end
         1: begin sender_gap_pct = 63; receiver_stall_pct = 23; end
         default: begin sender_gap_pct = 0; receiver_stall_pct = 0; end
      endcase
   endfunction

   // result side: check each transfer, then stall at random
   always @(posedge clock) begin
      adcdc_pkg::rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected result filtered_sample %0d clip_flag %0b", $time,
                     $signed(rsp_if.payload.filtered_sample), rsp_if.payload.clip_flag);
            mismatches++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_if.payload.filtered_sample !== want.filtered_sample) begin
               $display("%0t: filtered_sample expected %0d actual %0d", $time,
                        $signed(want.filtered_sample),
                        $signed(rsp_if.payload.filtered_sample));
               mismatches++;
            end
            if (rsp_if.payload.clip_flag !== want.clip_flag) begin
               $display("%0t: clip_flag expected %0b actual %0b", $time,
                        want.clip_flag, rsp_if.payload.clip_flag);
               mismatches++;
            end
         end
      end
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // stimulus
   initial begin
      script_row_type   row;
      signal_shape_type shape;
      int               burst_left;
      int               burst_pos;
      logic [adcdc_pkg::CLIP_LEVEL_W-1:0] seg_level;
      logic [adcdc_pkg::RUN_W-1:0]        seg_run;
      logic [31:0]                        junk;

      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      csr_we       <= 1'b0;
      csr_index    <= adcdc_pkg::CSR_CLIP_LEVEL;
      csr_wdata    <= '0;
      clear_filter_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed script
      set_pacing(0);
      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         row = script_row(n);
         if (row.is_csr) write_csr(row.csr_sel, row.csr_value);
         else send_sample(row.sample, row.known, row.known_rsp);
      end

      // random bursts, one clip setting per segment
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: begin
               seg_level = adcdc_pkg::CLIP_LEVEL_RESET;
               seg_run   = adcdc_pkg::CLIP_RUN_RESET;
            end
            1: begin seg_level = 15'd0;     seg_run = 4'd1;  end
            2: begin seg_level = 15'd32767; seg_run = 4'd15; end
            3: begin seg_level = 15'd0;     seg_run = 4'd15; end
            4: begin seg_level = 15'($urandom_range(32767, 20000));
                     seg_run   = 4'($urandom_range(15, 1)); end
            5: begin seg_level = 15'd32767; seg_run = 4'd1;  end
            6: begin seg_level = 15'($urandom_range(32767, 0)); seg_run = 4'd0; end
            7: begin seg_level = 15'd30000; seg_run = 4'd3;  end
            default: begin
               seg_level = adcdc_pkg::CLIP_LEVEL_RESET;
               seg_run   = adcdc_pkg::CLIP_RUN_RESET;
            end
         endcase
         // unused upper bits of the run length write carry junk
         junk = $urandom;
         write_csr(adcdc_pkg::CSR_CLIP_LEVEL, seg_level);
         write_csr(adcdc_pkg::CSR_CLIP_RUN,
                   {junk[adcdc_pkg::CSR_DATA_W-adcdc_pkg::RUN_W-1:0], seg_run});
         set_pacing(seg);
         burst_left = 0;
         burst_pos  = 0;
         for (int n = 0; n < SEG_ITEMS; n++) begin
            if (burst_left == 0) begin
               shape      = pick_shape();
               burst_left = $urandom_range(40, 4);
               burst_pos  = 0;
            end
            send_sample(shaped_sample(shape, burst_pos), 1'b0, '0);
            burst_left--;
            burst_pos++;
         end
      end

      // drain, then let any late result show up
      req_if.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS adc_decimator_clip_detect_unit");
      end else begin
         $display("FAIL adc_decimator_clip_detect_unit");
      end
      $finish;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("FAIL adc_decimator_clip_detect_unit");
      $finish;
   end

endmodule
